@@ src/pid_controller_clamped_macros.svh @@
// assertion macros used by the pid controller checker
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcc: check failed one cycle after condition");

// consequent must hold in the same cycle as the antecedent
`define PCC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcc: check failed in same cycle as condition");

`endif

@@ src/pcc_pkg.sv @@
// types, codes and microcode rom of the clamped pid controller
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

   // request and response payloads
   typedef struct packed {
      logic signed [31:0] measurement;
      logic        [31:0] time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               output_clamped;
      logic               zero_step;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic signed [31:0] target_value;
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic        [30:0] integral_limit;
      logic        [30:0] output_limit;
   } cfg_type;

   // register indexes on the csr port
   localparam int REG_W = 3;
   localparam logic [REG_W-1:0] REG_TARGET    = 3'd0;
   localparam logic [REG_W-1:0] REG_GAIN_P    = 3'd1;
   localparam logic [REG_W-1:0] REG_GAIN_I    = 3'd2;
   localparam logic [REG_W-1:0] REG_GAIN_D    = 3'd3;
   localparam logic [REG_W-1:0] REG_INT_LIMIT = 3'd4;
   localparam logic [REG_W-1:0] REG_OUT_LIMIT = 3'd5;

   // divider loop length, one quotient bit per step
   localparam int DIV_STEPS = 64;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_PREP,
      OP_MUL_ERR_DT,
      OP_INTEG,
      OP_MUL_P,
      OP_TERM_P,
      OP_MUL_I,
      OP_TERM_I,
      OP_MUL_D,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_FIX,
      OP_ADD_D,
      OP_OUTPUT
   } op_type;

   // sequencing conditions
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_WAIT_REQ,
      COND_WAIT_RSP,
      COND_IF_ZERO,
      COND_LOOP,
      COND_GOTO
   } cond_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   // program addresses
   localparam step_type STEP_FETCH   = 4'd0;
   localparam step_type STEP_PREP    = 4'd1;
   localparam step_type STEP_MUL_EDT = 4'd2;
   localparam step_type STEP_INTEG   = 4'd3;
   localparam step_type STEP_MUL_P   = 4'd4;
   localparam step_type STEP_TERM_P  = 4'd5;
   localparam step_type STEP_MUL_I   = 4'd6;
   localparam step_type STEP_TERM_I  = 4'd7;
   localparam step_type STEP_MUL_D   = 4'd8;
   localparam step_type STEP_DIV_IN  = 4'd9;
   localparam step_type STEP_DIV_LP  = 4'd10;
   localparam step_type STEP_DIV_FIX = 4'd11;
   localparam step_type STEP_ADD_D   = 4'd12;
   localparam step_type STEP_OUTPUT  = 4'd13;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // sequencer to datapath
   typedef struct packed {
      logic   fire;
      op_type op;
   } ctrl_type;

   // microcode program
   function automatic ctrl_word_type micro_rom(input step_type pc);
      ctrl_word_type w;
      begin
         unique case (pc)
            STEP_FETCH:   w = '{OP_LOAD,       COND_WAIT_REQ, STEP_FETCH};
            STEP_PREP:    w = '{OP_PREP,       COND_NEXT,     STEP_FETCH};
            STEP_MUL_EDT: w = '{OP_MUL_ERR_DT, COND_NEXT,     STEP_FETCH};
            STEP_INTEG:   w = '{OP_INTEG,      COND_NEXT,     STEP_FETCH};
            STEP_MUL_P:   w = '{OP_MUL_P,      COND_NEXT,     STEP_FETCH};
            STEP_TERM_P:  w = '{OP_TERM_P,     COND_NEXT,     STEP_FETCH};
            STEP_MUL_I:   w = '{OP_MUL_I,      COND_NEXT,     STEP_FETCH};
            STEP_TERM_I:  w = '{OP_TERM_I,     COND_NEXT,     STEP_FETCH};
            STEP_MUL_D:   w = '{OP_MUL_D,      COND_NEXT,     STEP_FETCH};
            STEP_DIV_IN:  w = '{OP_DIV_INIT,   COND_IF_ZERO,  STEP_OUTPUT};
            STEP_DIV_LP:  w = '{OP_DIV_STEP,   COND_LOOP,     STEP_DIV_LP};
            STEP_DIV_FIX: w = '{OP_DIV_FIX,    COND_NEXT,     STEP_FETCH};
            STEP_ADD_D:   w = '{OP_ADD_D,      COND_NEXT,     STEP_FETCH};
            STEP_OUTPUT:  w = '{OP_OUTPUT,     COND_WAIT_RSP, STEP_FETCH};
            default:      w = '{OP_NOP,        COND_GOTO,     STEP_FETCH};
         endcase
         return w;
      end
   endfunction

endpackage

`default_nettype wire

@@ src/pcc_sequencer.sv @@
// step counter, microcode rom and jump logic of the pid controller
`timescale 1ns / 1ps
`default_nettype none

module pcc_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              rsp_busy,
   input  wire logic              zero_step,
   output pcc_pkg::ctrl_type      ctrl,
   output logic                   idle
);
   import pcc_pkg::*;

   step_type        pc_ff, pc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   ctrl_word_type   word;
   logic            hold;

   // fetch the control word
   assign word = micro_rom(pc_ff);

   // wait conditions hold the step and block its operation
   always_comb begin
      hold = 1'b0;
      case (word.cond)
         COND_WAIT_REQ: hold = !req_valid;
         COND_WAIT_RSP: hold = rsp_busy;
         default:       hold = 1'b0;
      endcase
   end

   assign ctrl.fire = !hold;
   assign ctrl.op   = word.op;
   assign idle      = (pc_ff == STEP_FETCH);

   // next step
   always_comb begin
      pc_in = pc_ff + 1'b1;
      case (word.cond)
         COND_WAIT_REQ: if (hold) pc_in = pc_ff;
         COND_WAIT_RSP: pc_in = hold ? pc_ff : word.target;
         COND_IF_ZERO:  if (zero_step) pc_in = word.target;
         COND_LOOP:     if (count_ff != '0) pc_in = word.target;
         COND_GOTO:     pc_in = word.target;
         default:       pc_in = pc_ff + 1'b1;
      endcase
   end

   // divider loop counter
   always_comb begin
      count_in = count_ff;
      if (word.op == OP_DIV_INIT) begin
         count_in = DIV_LAST;
      end else if (word.op == OP_DIV_STEP) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= STEP_FETCH;
         count_ff <= '0;
      end else begin
         pc_ff    <= pc_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/pcc_datapath.sv @@
// registers, shared multiplier, clamp and divider step of the pid controller
`timescale 1ns / 1ps
`default_nettype none

module pcc_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcc_pkg::ctrl_type ctrl,
   input  wire pcc_pkg::cfg_type  cfg,
   input  wire logic              clear_integral,
   input  wire pcc_pkg::req_type  req_data,
   output logic                   zero_step,
   output pcc_pkg::rsp_type       rsp_data
);
   import pcc_pkg::*;

   localparam logic [63:0] DTERM_SAT = 64'h4000_0000_0000_0000;

   logic signed [31:0] meas_ff, meas_in;
   logic        [31:0] dt_ff, dt_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [32:0] diff_ff, diff_in;
   logic               zero_ff, zero_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] sum_ff, sum_in;
   logic        [63:0] num_ff, num_in;
   logic        [31:0] rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [31:0] prev_ff, prev_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [32:0] err_wide;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [63:0] shifted;
   logic signed [63:0] integ_acc;
   logic signed [63:0] integ_clamped;
   logic signed [63:0] drive_clamped;
   logic signed [63:0] out_lim;
   logic               out_hit;
   logic        [32:0] trial;
   logic               trial_ge;
   logic        [32:0] trial_diff;
   logic        [63:0] dmag;

   // symmetric clamp, upper test first
   function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] x,
                                                    input logic [30:0] lim);
      logic signed [63:0] l;
      begin
         l = signed'({33'd0, lim});
         if (x >= l) return l;
         else if (x <= -l) return -l;
         else return x;
      end
   endfunction

   // wide error, saturated to 32 bits in the prep step
   assign err_wide = 33'(cfg.target_value) - 33'(meas_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a = 33'(err_ff);
      mul_b = signed'({1'b0, dt_ff});
      case (ctrl.op)
         OP_MUL_P: begin
            mul_a = 33'(cfg.gain_p);
            mul_b = 33'(err_ff);
         end
         OP_MUL_I: begin
            mul_a = 33'(cfg.gain_i);
            mul_b = 33'(integ_ff);
         end
         OP_MUL_D: begin
            mul_a = 33'(cfg.gain_d);
            mul_b = diff_ff;
         end
         default: begin
            mul_a = 33'(err_ff);
            mul_b = signed'({1'b0, dt_ff});
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // product scaled back to q16.16 with floor rounding
   assign shifted = {{16{prod_ff[63]}}, prod_ff[63:16]};

   // integral and drive clamps
   assign integ_acc     = 64'(integ_ff) + shifted;
   assign integ_clamped = clamp_sym(integ_acc, cfg.integral_limit);
   assign drive_clamped = clamp_sym(sum_ff, cfg.output_limit);
   assign out_lim       = signed'({33'd0, cfg.output_limit});
   assign out_hit       = (sum_ff >= out_lim) || (sum_ff <= -out_lim);

   // restoring divide step on magnitudes
   assign trial      = {rem_ff, num_ff[63]};
   assign trial_ge   = (trial >= {1'b0, dt_ff});
   assign trial_diff = trial - {1'b0, dt_ff};

   // quotient magnitude saturated for the derivative term
   assign dmag = (num_ff > DTERM_SAT) ? DTERM_SAT : num_ff;

   // operation decode
   always_comb begin
      meas_in  = meas_ff;
      dt_in    = dt_ff;
      err_in   = err_ff;
      diff_in  = diff_ff;
      zero_in  = zero_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      integ_in = integ_ff;
      prev_in  = prev_ff;
      rsp_in   = rsp_ff;
      if (ctrl.fire) begin
         unique case (ctrl.op) inside
            OP_LOAD: begin
               meas_in = req_data.measurement;
               dt_in   = req_data.time_step;
            end
            OP_PREP: begin
               if (err_wide[32] != err_wide[31]) begin
                  err_in = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  err_in = err_wide[31:0];
               end
               diff_in = 33'(prev_ff) - 33'(meas_ff);
               zero_in = (dt_ff == '0);
            end
            OP_MUL_ERR_DT, OP_MUL_P, OP_MUL_I, OP_MUL_D: begin
               prod_in = mul_p[63:0];
            end
            OP_INTEG: begin
               integ_in = integ_clamped[31:0];
            end
            OP_TERM_P: begin
               sum_in = shifted;
            end
            OP_TERM_I: begin
               sum_in = sum_ff + shifted;
            end
            OP_DIV_INIT: begin
               neg_in = prod_ff[63];
               num_in = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
               rem_in = '0;
            end
            OP_DIV_STEP: begin
               rem_in = trial_ge ? trial_diff[31:0] : trial[31:0];
               num_in = {num_ff[62:0], trial_ge};
            end
            OP_DIV_FIX: begin
               num_in = neg_ff ? (~dmag + 64'd1) : dmag;
            end
            OP_ADD_D: begin
               sum_in = sum_ff + signed'(num_ff);
            end
            OP_OUTPUT: begin
               rsp_in.drive          = drive_clamped[31:0];
               rsp_in.output_clamped = out_hit;
               rsp_in.zero_step      = zero_ff;
               prev_in               = meas_ff;
            end
            default: begin
               meas_in = meas_ff;
            end
         endcase
      end
      if (clear_integral) begin
         integ_in = '0;
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      meas_ff <= meas_in;
      dt_ff   <= dt_in;
      err_ff  <= err_in;
      diff_ff <= diff_in;
      zero_ff <= zero_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign zero_step = zero_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ src/pid_controller_clamped.sv @@
// pid controller with measurement derivative and clamped integral, q16.16
// one request at a time: req_stall is high from accept until the program returns to fetch
// the 64-step restoring divide by time_step in the datapath is skipped when time_step is zero
// a stalled response holds the output step until it leaves
// synchronous reset clears the configuration registers, integral, last measurement and the sequencer
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_clamped (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire pcc_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output pcc_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [pcc_pkg::REG_W-1:0]  csr_index,
   input  wire logic [31:0]                csr_wdata
);
   import pcc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     clear_integral;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_busy;
   logic     idle;
   logic     zero_step;
   ctrl_type ctrl;

   // register writes; any gain or limit write clears the integral
   always_comb begin
      cfg_in         = cfg_ff;
      clear_integral = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_TARGET: cfg_in.target_value = csr_wdata;
            REG_GAIN_P: begin
               cfg_in.gain_p  = csr_wdata;
               clear_integral = 1'b1;
            end
            REG_GAIN_I: begin
               cfg_in.gain_i  = csr_wdata;
               clear_integral = 1'b1;
            end
            REG_GAIN_D: begin
               cfg_in.gain_d  = csr_wdata;
               clear_integral = 1'b1;
            end
            REG_INT_LIMIT: begin
               cfg_in.integral_limit = csr_wdata[30:0];
               clear_integral        = 1'b1;
            end
            REG_OUT_LIMIT: begin
               cfg_in.output_limit = csr_wdata[30:0];
               clear_integral      = 1'b1;
            end
            default: clear_integral = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // output register valid
   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.fire && ctrl.op == OP_OUTPUT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = !idle;

   // microcode sequencer
   pcc_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_busy  (rsp_busy),
      .zero_step (zero_step),
      .ctrl      (ctrl),
      .idle      (idle)
   );

   // arithmetic datapath
   pcc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .cfg            (cfg_ff),
      .clear_integral (clear_integral),
      .req_data       (req_data),
      .zero_step      (zero_step),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/pcc_checker.sv @@
// port-level assertions for the pid controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_clamped_macros.svh"

module pcc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire pcc_pkg::rsp_type  rsp_data
);
   import pcc_pkg::*;

   // a stalled response stays valid
   `PCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled response keeps its payload
   `PCC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // one request at a time: accept starts the program
   `PCC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall && !$rose(rsp_valid))

   // reset leaves the block idle and empty
   `PCC_ASSERT_NOW(a_reset_idle, clock, 1'b0, $past(reset), !rsp_valid && !req_stall)

endmodule

bind pid_controller_clamped pcc_checker u_pcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ verif/pid_controller_clamped_test.sv @@
// self-checking testbench of the clamped pid controller: directed table, then random requests
`timescale 1ns / 1ps

module pid_controller_clamped_test;
   import pcc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_GAP       = 4;
   localparam int END_WAIT       = 100;
   localparam int NUM_BLOCKS     = 16;
   localparam int BLOCK_ITEMS    = 100;

   // indexes past the last register, which the block ignores
   localparam logic [REG_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [REG_W-1:0] REG_SPARE_HI = 3'd7;

   localparam longint ERR_MAX = 64'sd2147483647;
   localparam longint ERR_MIN = -64'sd2147483648;
   localparam longint D_SAT   = 64'sd4611686018427387904;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_REQ,
      ROW_LIT
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [REG_W-1:0] index;
      logic [31:0]      value;
      req_type          req;
      rsp_type          lit;
   } row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [REG_W-1:0] csr_index;
   logic [31:0]      csr_wdata;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int errors        = 0;
   int quiet_cycles  = 0;

   rsp_type drive_due[$];
   row_type plan[$];

   // controller state as the block should hold it
   longint setpoint   = 0;
   longint k_p        = 0;
   longint k_i        = 0;
   longint k_d        = 0;
   longint lim_integ  = 0;
   longint lim_drive  = 0;
   longint integ_sum  = 0;
   longint last_meas  = 0;

   pid_controller_clamped dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // symmetric clamp, both compares inclusive so a zero limit forces zero
   function automatic longint hold_within(input longint x, input longint lim,
                                          output logic hit);
      hit = 1'b0;
      if (x >= lim) begin
         x = lim;
         hit = 1'b1;
      end
      if (x <= -lim) begin
         x = -lim;
         hit = 1'b1;
      end
      return x;
   endfunction

   // one control step: updates integral and last measurement, returns the drive
   function automatic rsp_type next_drive(input req_type r);
      longint  meas;
      longint  dt;
      longint  err;
      longint  p_term;
      longint  i_term;
      longint  d_term;
      longint  total;
      logic    dummy;
      logic    hit;
      rsp_type o;
      meas = longint'(signed'(r.measurement));
      dt   = longint'(r.time_step);
      err  = setpoint - meas;
      if (err > ERR_MAX) err = ERR_MAX;
      if (err < ERR_MIN) err = ERR_MIN;
      integ_sum = hold_within(integ_sum + ((err * dt) >>> 16), lim_integ, dummy);
      p_term = (k_p * err) >>> 16;
      i_term = (k_i * integ_sum) >>> 16;
      if (dt == 0) begin
         d_term = 0;
      end else begin
         d_term = (k_d * (last_meas - meas)) / dt;
         if (d_term > D_SAT) d_term = D_SAT;
         if (d_term < -D_SAT) d_term = -D_SAT;
      end
      total = hold_within(p_term + i_term + d_term, lim_drive, hit);
      last_meas = meas;
      o.drive          = total[31:0];
      o.output_clamped = hit;
      o.zero_step      = (dt == 0);
      return o;
   endfunction

   function automatic row_type csr_row(input logic [REG_W-1:0] index, input logic [31:0] value);
      row_type w;
      w = '0;
      w.kind  = ROW_CSR;
      w.index = index;
      w.value = value;
      return w;
   endfunction

   function automatic row_type req_row(input logic [31:0] meas, input logic [31:0] dt);
      row_type w;
      w = '0;
      w.kind              = ROW_REQ;
      w.req.measurement   = meas;
      w.req.time_step     = dt;
      return w;
   endfunction

   function automatic row_type lit_row(input logic [31:0] meas, input logic [31:0] dt,
                                       input logic [31:0] drive, input logic clamped,
                                       input logic zero);
      row_type w;
      w = req_row(meas, dt);
      w.kind               = ROW_LIT;
      w.lit.drive          = drive;
      w.lit.output_clamped = clamped;
      w.lit.zero_step      = zero;
      return w;
   endfunction

   // register write once the block has gone idle
   task automatic write_reg(input logic [REG_W-1:0] index, input logic [31:0] value);
      req_valid <= 1'b0;
      csr_wr_en <= 1'b0;
      while (drive_due.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         REG_TARGET: setpoint = longint'(signed'(value));
         REG_GAIN_P: begin
            k_p = longint'(signed'(value));
            integ_sum = 0;
         end
         REG_GAIN_I: begin
            k_i = longint'(signed'(value));
            integ_sum = 0;
         end
         REG_GAIN_D: begin
            k_d = longint'(signed'(value));
            integ_sum = 0;
         end
         REG_INT_LIMIT: begin
            lim_integ = longint'(value[30:0]);
            integ_sum = 0;
         end
         REG_OUT_LIMIT: begin
            lim_drive = longint'(value[30:0]);
            integ_sum = 0;
         end
         default: ;
      endcase
   endtask

   // present one request, leave valid high once it is taken
   task automatic send_request(input req_type r, input logic use_lit, input rsp_type lit);
      rsp_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 100)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = next_drive(r);
      drive_due.push_back(use_lit ? lit : predicted);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom();
         3: return 32'h0;
         default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(7))
         0: return 32'h0;
         1: return 32'h7FFFFFFF;
         2: return $urandom();
         default: return 32'($urandom_range(32'h1000, 32'h400000));
      endcase
   endfunction

   // new setting: sometimes only the setpoint, which keeps the integral
   task automatic random_config();
      write_reg(REG_TARGET, pick_gain());
      if ($urandom_range(3) != 0) begin
         write_reg(REG_GAIN_P, pick_gain());
         write_reg(REG_GAIN_I, pick_gain());
         write_reg(REG_GAIN_D, pick_gain());
         write_reg(REG_INT_LIMIT, pick_limit());
         write_reg(REG_OUT_LIMIT, pick_limit());
      end
      if ($urandom_range(7) == 0) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                            $urandom());
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_due.size() == 0) begin
            $error("response with no request pending: drive %0h", rsp_data.drive);
            errors++;
         end else begin
            want = drive_due.pop_front();
            if (rsp_data.drive !== want.drive) begin
               $error("drive: expected %0h, got %0h", want.drive, rsp_data.drive);
               errors++;
            end
            if (rsp_data.output_clamped !== want.output_clamped) begin
               $error("output_clamped: expected %0b, got %0b", want.output_clamped,
                      rsp_data.output_clamped);
               errors++;
            end
            if (rsp_data.zero_step !== want.zero_step) begin
               $error("zero_step: expected %0b, got %0b", want.zero_step, rsp_data.zero_step);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_type r;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      plan = '{
         // after reset every limit is zero, so the drive is forced to zero
         lit_row(32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 1'b1),
         lit_row(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b0),
         lit_row(32'h80000000, 32'h00010000, 32'h00000000, 1'b1, 1'b0),
         csr_row(REG_OUT_LIMIT, 32'h7FFFFFFF),
         csr_row(REG_INT_LIMIT, 32'h7FFFFFFF),
         csr_row(REG_GAIN_P, 32'h00010000),
         // unit proportional gain only: drive is minus the measurement
         lit_row(32'h00010000, 32'h00010000, 32'hFFFF0000, 1'b0, 1'b0),
         req_row(32'h80000000, 32'h00000000),
         // extreme gains and setpoint, error saturates, derivative saturates
         csr_row(REG_TARGET, 32'h7FFFFFFF),
         csr_row(REG_GAIN_P, 32'h7FFFFFFF),
         csr_row(REG_GAIN_I, 32'h80000000),
         csr_row(REG_GAIN_D, 32'h80000000),
         req_row(32'h80000000, 32'hFFFFFFFF),
         req_row(32'h7FFFFFFF, 32'h00000001),
         req_row(32'h00000000, 32'h00000001),
         csr_row(REG_TARGET, 32'h80000000),
         req_row(32'h7FFFFFFF, 32'hFFFFFFFF),
         req_row(32'h7FFFFFFF, 32'h00000000),
         // moderate settings so the integral builds up and clamps
         csr_row(REG_GAIN_P, 32'h00008000),
         csr_row(REG_GAIN_I, 32'h00020000),
         csr_row(REG_GAIN_D, 32'h00004000),
         csr_row(REG_TARGET, 32'h00050000),
         csr_row(REG_INT_LIMIT, 32'h00030000),
         csr_row(REG_OUT_LIMIT, 32'h00100000),
         req_row(32'h00010000, 32'h00008000),
         req_row(32'h00020000, 32'h00010000),
         req_row(32'h00048000, 32'h00000100),
         // setpoint write keeps the integral
         csr_row(REG_TARGET, 32'h00060000),
         req_row(32'h00040000, 32'h00010000),
         // spare indexes change nothing
         csr_row(REG_SPARE_LO, 32'hFFFFFFFF),
         csr_row(REG_SPARE_HI, 32'h12345678),
         req_row(32'h00038000, 32'h00020000),
         // top bit of a limit is dropped
         csr_row(REG_INT_LIMIT, 32'hFFFFFFFF),
         req_row(32'hFFF00000, 32'h00010000),
         csr_row(REG_INT_LIMIT, 32'h00000000),
         req_row(32'h00000000, 32'h00010000),
         csr_row(REG_OUT_LIMIT, 32'h80010000),
         req_row(32'hFF000000, 32'h00001000),
         // zero drive limit forces a zero, clamped drive
         csr_row(REG_OUT_LIMIT, 32'h00000000),
         lit_row(32'h12345678, 32'h00010000, 32'h00000000, 1'b1, 1'b0)
      };
      send_idle_pct = 14;
      stall_pct     = 57;
      foreach (plan[n]) begin
         if (plan[n].kind == ROW_CSR) begin
            write_reg(plan[n].index, plan[n].value);
         end else begin
            send_request(plan[n].req, plan[n].kind == ROW_LIT, plan[n].lit);
         end
      end

      // random part, a new setting per block
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (b == NUM_BLOCKS * 3 / 8) begin
            send_idle_pct = 57;
            stall_pct     = 14;
         end else if (b == NUM_BLOCKS * 3 / 4) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         random_config();
         for (int k = 0; k < BLOCK_ITEMS; k++) begin
            if ($urandom_range(9) < 7) begin
               r.measurement = setpoint[31:0] + 32'($urandom_range(0, 32'h100000)) - 32'h80000;
            end else begin
               r.measurement = $urandom();
            end
            case ($urandom_range(19)) inside
               0, 1:       r.time_step = 32'h0;
               2, 3, 4:    r.time_step = $urandom_range(1, 16);
               17, 18, 19: r.time_step = $urandom();
               default:    r.time_step = $urandom_range(1, 32'h40000);
            endcase
            send_request(r, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain
      while (drive_due.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
